### rtl/abd_pkg.sv
package abd_pkg;

    localparam int unsigned DataW    = 8;
    localparam int unsigned RamDepth = 4096;
    localparam int unsigned RamAddrW = $clog2(RamDepth);

    localparam logic [2:0] ModeMemRead  = 3'd0;
    localparam logic [2:0] ModeMemWrite = 3'd1;
    localparam logic [2:0] ModeIoWrite  = 3'd2;
    localparam logic [2:0] ModeSlice    = 3'd3;
    localparam logic [2:0] ModeFrameEnd = 3'd4;

    localparam logic [15:0] AddrRomEnd    = 16'h4000;
    localparam logic [15:0] AddrVideo     = 16'h8000;
    localparam logic [15:0] AddrWork      = 16'h9800;
    localparam logic [15:0] AddrPortOne   = 16'ha000;
    localparam logic [15:0] AddrPortTwo   = 16'ha080;
    localparam logic [15:0] AddrDip       = 16'ha100;
    localparam logic [15:0] AddrHScroll   = 16'ha130;
    localparam logic [15:0] AddrVScroll   = 16'ha140;
    localparam logic [15:0] AddrLatch     = 16'ha180;
    localparam logic [15:0] ReadRegionMsk = 16'hff80;
    localparam logic [11:0] VideoMask     = 12'hfff;
    localparam logic [10:0] WorkMask      = 11'h7ff;

    // radar attributes share the work ram, above the work area
    localparam logic [RamAddrW-1:0] RadarBase = RamAddrW'(12'h800);

    localparam logic [7:0] DipReset    = 8'hcb;
    localparam logic [7:0] VectorReset = 8'hff;
    localparam logic [7:0] PortTwoIdle = 8'hff;
    localparam logic [7:0] PortTwoS2   = 8'hbf;

    localparam logic [2:0] LatchExplosion = 3'd0;
    localparam logic [2:0] LatchIrqEnable = 3'd1;
    localparam logic [2:0] LatchSoundEn   = 3'd2;
    localparam logic [2:0] LatchFlip      = 3'd3;

    typedef enum logic [1:0] {
        SIDE_NONE      = 2'd0,
        SIDE_SOUND     = 2'd1,
        SIDE_EXPLOSION = 2'd2
    } t_side_kind;

    typedef enum logic [1:0] {
        RD_ZERO,
        RD_VIDEO,
        RD_WORK,
        RD_DIRECT
    } t_rd_src;

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic                rom_sel;
        t_rd_src             rd_src;
        logic [7:0]          rd_direct;
        logic                video_we;
        logic                work_we;
        logic [RamAddrW-1:0] video_addr;
        logic [RamAddrW-1:0] work_addr;
        t_side_kind          side_kind;
        logic [4:0]          side_index;
        logic [7:0]          side_value;
        logic                hscroll_we;
        logic                vscroll_we;
        logic                irq_en_we;
        logic                snd_en_we;
        logic                flip_we;
        logic                vector_we;
        logic                slice;
        logic                frame_end;
    } t_dec;

endpackage

### rtl/arcade_board_bus_decoder.sv
// a result is strobed on o_valid in the cycle after its start transfer is accepted
// throughput: one item per cycle once running; busy stays low outside the clear
// reset: synchronous, active low; afterwards busy is high while video ram and
// work ram (with the radar attributes) are cleared to zero
// the receiver cannot stall: each result is valid for exactly one cycle
module arcade_board_bus_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic [2:0]  i_mode,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_write_data,
    input  logic [6:0]  i_player_buttons,
    input  logic        i_start_two,
    input  logic        i_cpu_int_enabled,
    output logic        o_valid,
    output logic [7:0]  o_read_data,
    output logic        o_rom_select,
    output logic [1:0]  o_side_write_kind,
    output logic [4:0]  o_side_index,
    output logic [7:0]  o_side_value,
    output logic        o_irq_enable_out,
    output logic        o_sound_enable_out,
    output logic        o_screen_flip_out,
    output logic [7:0]  o_scroll_x_out,
    output logic [7:0]  o_scroll_y_out,
    output logic        o_irq_deliver,
    output logic [7:0]  o_int_vector_out
);

    localparam int unsigned AW = abd_pkg::RamAddrW;

    abd_pkg::t_state     r_state, n_state;
    logic [AW-1:0]       r_clr_addr;
    logic                clearing;
    logic                accept;
    abd_pkg::t_dec       dec;

    logic                video_we, work_we;
    logic [AW-1:0]       video_addr, work_addr;
    logic [7:0]          video_wdata, work_wdata;
    logic [7:0]          video_rdata, work_rdata;

    logic [7:0]          r_dip;
    logic [7:0]          r_hscroll, r_vscroll;
    logic                r_flip, r_irq_en, r_snd_en;
    logic [7:0]          r_vector;
    logic                r_pending;
    logic                r_valid;
    logic                deliver;

    abd_pkg::t_rd_src    r_rd_src;
    logic [7:0]          r_rd_direct;
    logic                r_rom;
    abd_pkg::t_side_kind r_kind;
    logic [4:0]          r_sidx;
    logic [7:0]          r_sval;
    logic                r_deliver;
    logic [7:0]          r_vec;

    abd_decode u_decode (
        .i_mode           (i_mode),
        .i_address        (i_address),
        .i_write_data     (i_write_data),
        .i_player_buttons (i_player_buttons),
        .i_start_two      (i_start_two),
        .i_dip            (r_dip),
        .o_dec            (dec)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            abd_pkg::ST_CLEAR: begin
                if (r_clr_addr == '1) begin
                    n_state = abd_pkg::ST_RUN;
                end
            end
            abd_pkg::ST_RUN: n_state = abd_pkg::ST_RUN;
            default: n_state = abd_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        clearing = (r_state == abd_pkg::ST_CLEAR);
        busy     = clearing;
    end

    assign accept  = start && !busy;
    assign deliver = dec.slice && r_pending && i_cpu_int_enabled;

    // memory ports: clear sweep, or the accepted bus transfer
    always_comb begin
        if (clearing) begin
            video_we    = 1'b1;
            work_we     = 1'b1;
            video_addr  = r_clr_addr;
            work_addr   = r_clr_addr;
            video_wdata = '0;
            work_wdata  = '0;
        end else begin
            video_we    = accept && dec.video_we;
            work_we     = accept && dec.work_we;
            video_addr  = dec.video_addr;
            work_addr   = dec.work_addr;
            video_wdata = i_write_data;
            work_wdata  = i_write_data;
        end
    end

    abd_ram #(
        .Width (abd_pkg::DataW),
        .Depth (abd_pkg::RamDepth)
    ) u_video_ram (
        .i_clk   (i_clk),
        .i_we    (video_we),
        .i_addr  (video_addr),
        .i_wdata (video_wdata),
        .o_rdata (video_rdata)
    );

    abd_ram #(
        .Width (abd_pkg::DataW),
        .Depth (abd_pkg::RamDepth)
    ) u_work_ram (
        .i_clk   (i_clk),
        .i_we    (work_we),
        .i_addr  (work_addr),
        .i_wdata (work_wdata),
        .o_rdata (work_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= abd_pkg::ST_CLEAR;
            r_clr_addr <= '0;
            r_dip      <= abd_pkg::DipReset;
            r_hscroll  <= '0;
            r_vscroll  <= '0;
            r_flip     <= 1'b0;
            r_irq_en   <= 1'b0;
            r_snd_en   <= 1'b0;
            r_vector   <= abd_pkg::VectorReset;
            r_pending  <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (clearing) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cfg_we) begin
                r_dip <= i_cfg_wdata;
            end
            r_valid <= accept;
            if (accept) begin
                if (dec.hscroll_we) r_hscroll <= i_write_data;
                if (dec.vscroll_we) r_vscroll <= i_write_data;
                if (dec.flip_we)    r_flip    <= i_write_data[0];
                if (dec.irq_en_we)  r_irq_en  <= i_write_data[0];
                if (dec.snd_en_we)  r_snd_en  <= i_write_data[0];
                if (dec.vector_we)  r_vector  <= i_write_data;
                if (deliver) begin
                    r_pending <= 1'b0;
                end else if (dec.frame_end && r_irq_en) begin
                    r_pending <= 1'b1;
                end
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_src    <= dec.rd_src;
            r_rd_direct <= dec.rd_direct;
            r_rom       <= dec.rom_sel;
            r_kind      <= dec.side_kind;
            r_sidx      <= dec.side_index;
            r_sval      <= dec.side_value;
            r_deliver   <= deliver;
            r_vec       <= deliver ? r_vector : 8'd0;
        end
    end

    always_comb begin
        unique case (r_rd_src)
            abd_pkg::RD_ZERO:   o_read_data = '0;
            abd_pkg::RD_VIDEO:  o_read_data = video_rdata;
            abd_pkg::RD_WORK:   o_read_data = work_rdata;
            abd_pkg::RD_DIRECT: o_read_data = r_rd_direct;
            default:            o_read_data = '0;
        endcase
    end

    assign o_valid            = r_valid;
    assign o_rom_select       = r_rom;
    assign o_side_write_kind  = r_kind;
    assign o_side_index       = r_sidx;
    assign o_side_value       = r_sval;
    assign o_irq_enable_out   = r_irq_en;
    assign o_sound_enable_out = r_snd_en;
    assign o_screen_flip_out  = r_flip;
    assign o_scroll_x_out     = r_hscroll;
    assign o_scroll_y_out     = r_vscroll;
    assign o_irq_deliver      = r_deliver;
    assign o_int_vector_out   = r_vec;

endmodule

### rtl/abd_ram.sv
module abd_ram #(
    parameter int unsigned Width = 8,
    parameter int unsigned Depth = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/abd_decode.sv
module abd_decode (
    input  logic [2:0]   i_mode,
    input  logic [15:0]  i_address,
    input  logic [7:0]   i_write_data,
    input  logic [6:0]   i_player_buttons,
    input  logic         i_start_two,
    input  logic [7:0]   i_dip,
    output abd_pkg::t_dec o_dec
);

    logic in_video;
    logic in_work;
    logic in_radar;
    logic in_sound;
    logic in_latch;

    assign in_video = (i_address[15:12] == abd_pkg::AddrVideo[15:12]);
    assign in_work  = (i_address[15:11] == abd_pkg::AddrWork[15:11]);
    assign in_radar = (i_address[15:4] == abd_pkg::AddrPortOne[15:4]);
    assign in_sound = (i_address[15:5] == abd_pkg::AddrDip[15:5]);
    assign in_latch = (i_address[15:3] == abd_pkg::AddrLatch[15:3]);

    always_comb begin
        o_dec            = '0;
        o_dec.rd_src     = abd_pkg::RD_ZERO;
        o_dec.side_kind  = abd_pkg::SIDE_NONE;
        o_dec.video_addr = i_address[11:0] & abd_pkg::VideoMask;
        o_dec.work_addr  = {1'b0, i_address[10:0] & abd_pkg::WorkMask};
        if (i_mode == abd_pkg::ModeMemRead) begin
            priority if (i_address < abd_pkg::AddrRomEnd) begin
                o_dec.rom_sel = 1'b1;
            end else if (in_video) begin
                o_dec.rd_src = abd_pkg::RD_VIDEO;
            end else if (in_work) begin
                o_dec.rd_src = abd_pkg::RD_WORK;
            end else if ((i_address & abd_pkg::ReadRegionMsk) == abd_pkg::AddrPortOne) begin
                o_dec.rd_src    = abd_pkg::RD_DIRECT;
                o_dec.rd_direct = ~{i_player_buttons, 1'b0};
            end else if ((i_address & abd_pkg::ReadRegionMsk) == abd_pkg::AddrPortTwo) begin
                o_dec.rd_src    = abd_pkg::RD_DIRECT;
                o_dec.rd_direct = i_start_two ? abd_pkg::PortTwoS2 : abd_pkg::PortTwoIdle;
            end else if ((i_address & abd_pkg::ReadRegionMsk) == abd_pkg::AddrDip) begin
                o_dec.rd_src    = abd_pkg::RD_DIRECT;
                o_dec.rd_direct = i_dip;
            end else begin
                o_dec.rd_src = abd_pkg::RD_ZERO;
            end
        end else if (i_mode == abd_pkg::ModeMemWrite) begin
            priority if (in_video) begin
                o_dec.video_we = 1'b1;
            end else if (in_work) begin
                o_dec.work_we = 1'b1;
            end else if (in_radar) begin
                o_dec.work_we   = 1'b1;
                o_dec.work_addr = abd_pkg::RadarBase | {8'd0, i_address[3:0]};
            end else if (in_sound) begin
                o_dec.side_kind  = abd_pkg::SIDE_SOUND;
                o_dec.side_index = i_address[4:0];
                o_dec.side_value = i_write_data;
            end else if (i_address == abd_pkg::AddrHScroll) begin
                o_dec.hscroll_we = 1'b1;
            end else if (i_address == abd_pkg::AddrVScroll) begin
                o_dec.vscroll_we = 1'b1;
            end else if (in_latch) begin
                unique case (i_address[2:0])
                    abd_pkg::LatchExplosion: begin
                        o_dec.side_kind  = abd_pkg::SIDE_EXPLOSION;
                        o_dec.side_value = {7'd0, i_write_data[0]};
                    end
                    abd_pkg::LatchIrqEnable: o_dec.irq_en_we = 1'b1;
                    abd_pkg::LatchSoundEn:   o_dec.snd_en_we = 1'b1;
                    abd_pkg::LatchFlip:      o_dec.flip_we   = 1'b1;
                    default: ;
                endcase
            end else begin
                o_dec.video_we = 1'b0;
            end
        end else if (i_mode == abd_pkg::ModeIoWrite) begin
            o_dec.vector_we = (i_address[7:0] == 8'd0);
        end else if (i_mode == abd_pkg::ModeSlice) begin
            o_dec.slice = 1'b1;
        end else if (i_mode == abd_pkg::ModeFrameEnd) begin
            o_dec.frame_end = 1'b1;
        end
    end

endmodule
